// ===== sv/fht_pkg.sv =====
// ----------------------------------------------------------------------------
// fht_pkg
// Shared types, widths, codes and the CRC byte step of the flow hash table.
// ----------------------------------------------------------------------------
package fht_pkg;

  localparam int BUCKET_BITS_DEF = 10;
  localparam int WAYS_DEF        = 4;

  localparam int OP_W        = 2;
  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 16;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 12;
  localparam int COUNT_OUT_W = 13;
  localparam int CRC_W       = 16;
  localparam int KEY_BYTES   = 12;
  localparam int KEY_W       = KEY_BYTES * 8;
  localparam int BYTE_CNT_W  = $clog2(KEY_BYTES);

  localparam int IDX_CFG_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;

  localparam logic [IDX_CFG_W-1:0] INDEX_BITS_RESET = 4'd10;
  localparam logic [CRC_W-1:0]     CRC_POLY_RESET   = 16'h8005;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INDEX_BITS = 1'd0,
    REG_CRC_POLY   = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_BASE,
    S_LOOKUP,
    S_CHECK,
    S_DECIDE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             done;
    logic [CRC_W-1:0] crc;
  } crc_result_t;

  // msb-first crc over one byte, eight shift steps
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0]       data,
                                                input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/fht_channels.sv =====
// ----------------------------------------------------------------------------
// fht channels
// Valid/ready request and response channels of the flow hash table.
// ----------------------------------------------------------------------------
interface fht_req_if
  import fht_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [ADDR_W-1:0]     local_address;
  logic [ADDR_W-1:0]     remote_address;
  logic [PORT_W-1:0]     local_port_num;
  logic [PORT_W-1:0]     remote_port_num;

  modport source (
    output valid, operation, local_address, remote_address, local_port_num,
           remote_port_num,
    input  ready
  );
  modport sink (
    input  valid, operation, local_address, remote_address, local_port_num,
           remote_port_num,
    output ready
  );
endinterface

interface fht_rsp_if
  import fht_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [SLOT_OUT_W-1:0]  entry_slot;
  logic [COUNT_OUT_W-1:0] flow_count;

  modport source (
    output valid, status, entry_slot, flow_count,
    input  ready
  );
  modport sink (
    input  valid, status, entry_slot, flow_count,
    output ready
  );
endinterface

// ===== sv/fht_ram.sv =====
// ----------------------------------------------------------------------------
// fht_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fht_crc.sv =====
// ----------------------------------------------------------------------------
// fht_crc
// Byte-serial CRC-16 engine: one key byte per cycle.
// ----------------------------------------------------------------------------
module fht_crc
  import fht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key_bytes,
  input  logic [CRC_W-1:0]  poly,
  output crc_result_t       result
);

  logic                  busy;
  logic                  done;
  logic [BYTE_CNT_W-1:0] byte_cnt;
  logic [KEY_W-1:0]      shift;
  logic [CRC_W-1:0]      crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && byte_cnt == BYTE_CNT_W'(KEY_BYTES - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift    <= key_bytes;
      crc      <= '0;
      byte_cnt <= '0;
    end else if (busy) begin
      crc      <= crc_byte(crc, shift[KEY_W-1 -: 8], poly);
      shift    <= {shift[KEY_W-9:0], 8'h00};
      byte_cnt <= byte_cnt + 1'b1;
    end
  end

  assign result.done = done;
  assign result.crc  = crc;

endmodule

// ===== sv/flow_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// flow_hash_table_top
// Exact-match four-tuple flow table: CRC-16 bucket hash, ways probed in turn.
// ----------------------------------------------------------------------------
// a request is hashed by the byte-serial crc, then one RAM read and one compare
//   are made per way
// one request at a time: the shared crc engine and the single read port of the
//   slot RAM serve it, and a new request is taken only back in the idle state
// reset: a clearing pass writes every slot invalid, with the request channel
//   not ready meanwhile
module flow_hash_table_top
  import fht_pkg::*;
#(
  parameter int BUCKET_BITS = BUCKET_BITS_DEF,
  parameter int WAYS        = WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fht_req_if.sink               req,
  fht_rsp_if.source             rsp
);

  localparam int NUM_SLOTS = (1 << BUCKET_BITS) * WAYS;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int COUNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int WAY_W     = $clog2(WAYS + 1);
  localparam int ENTRY_W   = KEY_W + 1;

  state_t state, state_next;

  logic [IDX_CFG_W-1:0] index_bits;
  logic [CRC_W-1:0]     crc_poly;

  logic [OP_W-1:0]    op;
  logic [KEY_W-1:0]   key;
  logic [SLOT_W-1:0]  base;
  logic [WAY_W-1:0]   way;
  logic [SLOT_W-1:0]  cur_slot;
  logic [SLOT_W-1:0]  clr_cnt;
  logic               hit, have_free;
  logic [SLOT_W-1:0]  hit_slot, free_slot;
  logic [COUNT_W-1:0] flows_held, flows_next;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [COUNT_W-1:0]  res_count;

  logic                accept;
  logic [KEY_W-1:0]    req_key, req_bytes;
  crc_result_t         crc_res;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  logic                do_insert, do_delete;
  status_t             dec_status;
  logic [SLOT_W-1:0]   dec_slot;

  logic [4:0]          sat_bits;
  logic [CRC_W-1:0]    hash_shifted;

  logic [SLOT_OUT_W+SLOT_W-1:0]   slot_ext;
  logic [COUNT_OUT_W+COUNT_W-1:0] count_ext;

  assign accept = req.valid && req.ready;

  // key in stored word order, and in hashing order (low byte of each half first)
  assign req_key = {req.local_address, req.remote_address,
                    req.local_port_num, req.remote_port_num};
  assign req_bytes = {req.local_address[23:16],  req.local_address[31:24],
                      req.local_address[7:0],    req.local_address[15:8],
                      req.remote_address[23:16], req.remote_address[31:24],
                      req.remote_address[7:0],   req.remote_address[15:8],
                      req.local_port_num[7:0],   req.local_port_num[15:8],
                      req.remote_port_num[7:0],  req.remote_port_num[15:8]};

  fht_crc u_crc (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .key_bytes (req_bytes),
    .poly      (crc_poly),
    .result    (crc_res)
  );

  fht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= INDEX_BITS_RESET;
      crc_poly   <= CRC_POLY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INDEX_BITS: index_bits <= cfg_data[IDX_CFG_W-1:0];
        REG_CRC_POLY:   crc_poly   <= cfg_data[CRC_W-1:0];
      endcase
    end
  end

  // bucket index: top bits of the crc, saturated to the table size
  always_comb begin
    sat_bits = ({1'b0, index_bits} > 5'(BUCKET_BITS)) ? 5'(BUCKET_BITS)
                                                      : {1'b0, index_bits};
    hash_shifted = crc_res.crc >> (5'd16 - sat_bits);
  end

  assign cur_slot = base + SLOT_W'(way);

  // outcome of the probe
  always_comb begin
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    dec_status = ST_NOT_FOUND;
    dec_slot   = '0;
    flows_next = flows_held;
    unique case (op)
      OP_INSERT: begin
        if (hit) begin
          dec_status = ST_EXISTS;
          dec_slot   = hit_slot;
        end else if (have_free) begin
          do_insert  = 1'b1;
          dec_status = ST_INSERTED;
          dec_slot   = free_slot;
          flows_next = flows_held + 1'b1;
        end else begin
          dec_status = ST_FULL;
        end
      end
      OP_SEARCH: begin
        if (hit) begin
          dec_status = ST_FOUND;
          dec_slot   = hit_slot;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          do_delete  = 1'b1;
          dec_status = ST_DELETED;
          dec_slot   = hit_slot;
          if (flows_held != '0) begin
            flows_next = flows_held - 1'b1;
          end
        end
      end
      default: begin
        dec_status = ST_NOT_FOUND;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == SLOT_W'(NUM_SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_HASH;
      end
      S_HASH: begin
        if (crc_res.done) state_next = S_BASE;
      end
      S_BASE:   state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_CHECK;
      S_CHECK: begin
        state_next = (way == WAY_W'(WAYS - 1)) ? S_DECIDE : S_LOOKUP;
      end
      S_DECIDE: state_next = S_EMIT;
      S_EMIT: begin
        if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      end
      default:  state_next = S_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    ram_raddr = cur_slot;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_DECIDE: begin
        ram_we    = do_insert || do_delete;
        ram_waddr = do_insert ? free_slot : hit_slot;
        ram_wdata = {do_insert, key};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      flows_held <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_DECIDE) begin
        flows_held <= flows_next;
      end
      if (state == S_EMIT && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.operation;
      key <= req_key;
    end
    if (state == S_BASE) begin
      base      <= SLOT_W'(hash_shifted[BUCKET_BITS-1:0]) * SLOT_W'(WAYS);
      way       <= '0;
      hit       <= 1'b0;
      have_free <= 1'b0;
      hit_slot  <= '0;
      free_slot <= '0;
    end
    if (state == S_CHECK) begin
      way <= way + 1'b1;
      if (ram_rdata[KEY_W]) begin
        if (!hit && ram_rdata[KEY_W-1:0] == key) begin
          hit      <= 1'b1;
          hit_slot <= cur_slot;
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        free_slot <= cur_slot;
      end
    end
    if (state == S_DECIDE) begin
      res_status <= dec_status;
      res_slot   <= dec_slot;
      res_count  <= flows_next;
    end
  end

  // response word, masked to the port widths
  assign slot_ext  = {{SLOT_OUT_W{1'b0}}, res_slot};
  assign count_ext = {{COUNT_OUT_W{1'b0}}, res_count};

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!rsp.valid || rsp.ready)) begin
      rsp.status     <= res_status;
      rsp.entry_slot <= slot_ext[SLOT_OUT_W-1:0];
      rsp.flow_count <= count_ext[COUNT_OUT_W-1:0];
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flow hash table: requests go in over the
// request channel, and each response word is checked against a scoreboard
// model of the slot store, the CRC bucket hash and the flow count.
// Directed lookups and single-bucket cases come first, then random phases
// under several index widths and polynomials.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fht_pkg::*;

  localparam int TB_BUCKET_BITS = BUCKET_BITS_DEF;
  localparam int TB_WAYS        = WAYS_DEF;
  localparam int SLOT_COUNT     = (1 << TB_BUCKET_BITS) * TB_WAYS;
  localparam int STALL_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RECENT_DEPTH   = 96;

  localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] local_address;
    logic [ADDR_W-1:0] remote_address;
    logic [PORT_W-1:0] local_port_num;
    logic [PORT_W-1:0] remote_port_num;
  } flow_key_t;

  typedef struct packed {
    status_t                status;
    logic [SLOT_OUT_W-1:0]  entry_slot;
    logic [COUNT_OUT_W-1:0] flow_count;
  } flow_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fht_req_if req_ch ();
  fht_rsp_if rsp_ch ();

  flow_hash_table_top #(
    .BUCKET_BITS (TB_BUCKET_BITS),
    .WAYS        (TB_WAYS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // scoreboard copy of the flow store and registers
  bit                   slot_live [SLOT_COUNT];
  flow_key_t            slot_flow [SLOT_COUNT];
  int unsigned          flows_live     = 0;
  logic [IDX_CFG_W-1:0] index_bits_now = INDEX_BITS_RESET;
  logic [CRC_W-1:0]     poly_now       = CRC_POLY_RESET;

  flow_result_t expected_results [$];
  flow_key_t    recent_flows [$];
  int           error_count = 0;
  bit           idling_on   = 1'b1;
  int           quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // msb-first crc, each 16-bit half fed low byte first
  function automatic logic [CRC_W-1:0] flow_crc(flow_key_t k);
    logic [CRC_W-1:0] crc;
    logic [15:0]      halves [6];
    logic [7:0]       octet;
    halves[0] = k.local_address[31:16];
    halves[1] = k.local_address[15:0];
    halves[2] = k.remote_address[31:16];
    halves[3] = k.remote_address[15:0];
    halves[4] = k.local_port_num;
    halves[5] = k.remote_port_num;
    crc = '0;
    for (int h = 0; h < 6; h++) begin
      for (int hi = 0; hi < 2; hi++) begin
        octet = (hi == 0) ? halves[h][7:0] : halves[h][15:8];
        crc   = crc ^ {octet, 8'h00};
        for (int b = 0; b < 8; b++) begin
          if (crc[CRC_W-1]) begin
            crc = {crc[CRC_W-2:0], 1'b0} ^ poly_now;
          end else begin
            crc = {crc[CRC_W-2:0], 1'b0};
          end
        end
      end
    end
    return crc;
  endfunction

  function automatic flow_result_t apply_flow_request(logic [OP_W-1:0] op, flow_key_t k);
    flow_result_t res;
    int           bits;
    int           bucket;
    int           s;
    int           hit_slot;
    int           free_slot;
    bit           hit;
    bit           have_free;
    bits      = (index_bits_now > TB_BUCKET_BITS) ? TB_BUCKET_BITS : int'(index_bits_now);
    bucket    = int'(flow_crc(k) >> (CRC_W - bits));
    hit       = 1'b0;
    have_free = 1'b0;
    hit_slot  = 0;
    free_slot = 0;
    for (int w = 0; w < TB_WAYS; w++) begin
      s = (bucket * TB_WAYS + w) % SLOT_COUNT;
      if (slot_live[s]) begin
        if (!hit && slot_flow[s] == k) begin
          hit      = 1'b1;
          hit_slot = s;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_slot = s;
      end
    end
    res.status     = ST_NOT_FOUND;
    res.entry_slot = '0;
    case (op)
      OP_INSERT: begin
        if (hit) begin
          res.status     = ST_EXISTS;
          res.entry_slot = SLOT_OUT_W'(hit_slot);
        end else if (have_free) begin
          slot_live[free_slot] = 1'b1;
          slot_flow[free_slot] = k;
          flows_live++;
          res.status     = ST_INSERTED;
          res.entry_slot = SLOT_OUT_W'(free_slot);
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_SEARCH: begin
        if (hit) begin
          res.status     = ST_FOUND;
          res.entry_slot = SLOT_OUT_W'(hit_slot);
        end
      end
      OP_DELETE: begin
        if (hit) begin
          slot_live[hit_slot] = 1'b0;
          if (flows_live > 0) flows_live--;
          res.status     = ST_DELETED;
          res.entry_slot = SLOT_OUT_W'(hit_slot);
        end
      end
      default: ;
    endcase
    res.flow_count = COUNT_OUT_W'(flows_live);
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic flow_key_t random_flow();
    flow_key_t         k;
    logic [ADDR_W-1:0] w;
    k.local_address   = random_word();
    k.remote_address  = random_word();
    w                 = random_word();
    k.local_port_num  = w[PORT_W-1:0];
    w                 = random_word();
    k.remote_port_num = w[PORT_W-1:0];
    return k;
  endfunction

  // valid stays high after acceptance until the next item or the next drain
  task automatic send_request(logic [OP_W-1:0] op, flow_key_t k);
    int gap;
    gap = idling_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.operation       <= op;
    req_ch.local_address   <= k.local_address;
    req_ch.remote_address  <= k.remote_address;
    req_ch.local_port_num  <= k.local_port_num;
    req_ch.remote_port_num <= k.remote_port_num;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_results.push_back(apply_flow_request(op, k));
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_INDEX_BITS: index_bits_now = value[IDX_CFG_W-1:0];
      REG_CRC_POLY:   poly_now       = value;
      default: ;
    endcase
  endtask

  // lookups mostly of flows inserted in this phase, inserts mostly of fresh keys
  task automatic send_random_request();
    int               pick;
    bit               reuse;
    logic [OP_W-1:0]  op;
    flow_key_t        k;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      op = OP_INSERT;
    end else if (pick < 75) begin
      op = OP_SEARCH;
    end else if (pick < 95) begin
      op = OP_DELETE;
    end else begin
      op = OP_UNDEFINED;
    end
    reuse = (recent_flows.size() > 0) &&
            ($urandom_range(0, 99) < ((op == OP_INSERT) ? 25 : 75));
    if (reuse) begin
      k = recent_flows[$urandom_range(0, recent_flows.size() - 1)];
    end else begin
      k = random_flow();
      if (op == OP_INSERT) begin
        recent_flows.push_back(k);
        if (recent_flows.size() > RECENT_DEPTH) void'(recent_flows.pop_front());
      end
    end
    send_request(op, k);
  endtask

  task automatic test_directed_lookups();
    flow_key_t zero_key;
    flow_key_t ones_key;
    flow_key_t mixed_key;
    zero_key  = '0;
    ones_key  = '1;
    mixed_key = {32'hc0a8_0001, 32'h0a00_00fe, 16'h0050, 16'hffff};
    wait_for_drain();
    write_register(REG_INDEX_BITS, INDEX_BITS_RESET);
    write_register(REG_CRC_POLY, CRC_POLY_RESET);
    send_request(OP_SEARCH, zero_key);
    send_request(OP_INSERT, zero_key);
    send_request(OP_INSERT, ones_key);
    send_request(OP_INSERT, zero_key);
    send_request(OP_INSERT, mixed_key);
    send_request(OP_SEARCH, ones_key);
    // undefined opcode misses even on a held flow
    send_request(OP_UNDEFINED, ones_key);
    send_request(OP_DELETE, zero_key);
    send_request(OP_DELETE, zero_key);
    send_request(OP_SEARCH, zero_key);
    send_request(OP_SEARCH, mixed_key);
  endtask

  task automatic test_single_bucket();
    flow_key_t group [5];
    for (int i = 0; i < 5; i++) begin
      group[i]                 = random_flow();
      group[i].remote_port_num = PORT_W'(i);
    end
    // zero index bits put every flow in bucket 0, so the fifth insert overflows
    wait_for_drain();
    write_register(REG_INDEX_BITS, '0);
    for (int i = 0; i < 5; i++) send_request(OP_INSERT, group[i]);
    send_request(OP_DELETE, group[1]);
    send_request(OP_INSERT, group[4]);
    send_request(OP_SEARCH, group[4]);
    // index width above the bucket bits saturates
    wait_for_drain();
    write_register(REG_INDEX_BITS, 16'd15);
    send_request(OP_SEARCH, group[0]);
    send_request(OP_INSERT, group[0]);
    send_request(OP_SEARCH, group[0]);
  endtask

  task automatic run_random_phase(logic [IDX_CFG_W-1:0] bits, logic [CRC_W-1:0] poly,
                                  int count);
    wait_for_drain();
    write_register(REG_INDEX_BITS, CFG_DATA_W'(bits));
    write_register(REG_CRC_POLY, poly);
    recent_flows.delete();
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) idling_on = ($urandom_range(0, 3) != 0);
      send_random_request();
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = REG_INDEX_BITS;
    cfg_data               = '0;
    req_ch.valid           = 1'b0;
    req_ch.operation       = OP_INSERT;
    req_ch.local_address   = '0;
    req_ch.remote_address  = '0;
    req_ch.local_port_num  = '0;
    req_ch.remote_port_num = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_directed_lookups();
    test_single_bucket();
    run_random_phase(4'd10, 16'h8005, 380);
    run_random_phase(4'd2, 16'hffff, 250);
    run_random_phase(4'd0, 16'h1021, 120);
    run_random_phase(4'd15, 16'h0000, 180);
    run_random_phase(4'd6, CRC_W'($urandom), 250);
    run_random_phase(4'd1, CRC_W'($urandom), 200);

    wait_for_drain();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // response side: random back-pressure, each word checked against the oldest expectation
  initial begin : result_checker
    flow_result_t want;
    int           gap;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = idling_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual status %0d slot %0d count %0d",
                 $time, rsp_ch.status, rsp_ch.entry_slot, rsp_ch.flow_count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.entry_slot !== want.entry_slot) begin
          $display("%0t: entry_slot mismatch: expected %0d actual %0d",
                   $time, want.entry_slot, rsp_ch.entry_slot);
          error_count++;
        end
        if (rsp_ch.flow_count !== want.flow_count) begin
          $display("%0t: flow_count mismatch: expected %0d actual %0d",
                   $time, want.flow_count, rsp_ch.flow_count);
          error_count++;
        end
      end
    end
  end

  // covers the clearing pass after reset as well as a hung handshake
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
sv/fht_pkg.sv
sv/fht_channels.sv
sv/fht_ram.sv
sv/fht_crc.sv
sv/flow_hash_table_top.sv
verif/tb_top.sv
